### rtl/gls_pkg.sv
// Shared types and constants for the grid line-of-sight block.
// No dependencies; imported by gls_walker, grid_line_of_sight_top and the testbench.
package gls_pkg;

    localparam int CRD_W      = 14;
    localparam int CELL_IN_W  = 6;
    localparam int COUNT_W    = 7;

    localparam int DEF_GRID_WIDTH  = 64;
    localparam int DEF_GRID_HEIGHT = 64;
    localparam int DEF_FRAC_BITS   = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_INIT,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        CRN_NONE,
        CRN_SIDE_X,
        CRN_SIDE_Y
    } corner_t;

    typedef struct packed {
        logic load;
        logic init;
        logic step;
    } walk_ctl_t;

    typedef struct packed {
        logic more;
        logic in_grid;
    } walk_sts_t;

    function automatic int cell_width(input int frac);
        return (frac < CRD_W) ? (CRD_W - frac) : 1;
    endfunction

endpackage

### rtl/gls_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gls_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/gls_walker.sv
// Segment setup and exact cell traversal; emits one map address per step.
// Depends on gls_pkg.
module gls_walker #(
    parameter int GRID_WIDTH  = gls_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = gls_pkg::DEF_GRID_HEIGHT,
    parameter int FRAC_BITS   = gls_pkg::DEF_FRAC_BITS
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  gls_pkg::walk_ctl_t                             ctl,
    input  logic [gls_pkg::CRD_W-1:0]                      start_x,
    input  logic [gls_pkg::CRD_W-1:0]                      start_y,
    input  logic [gls_pkg::CRD_W-1:0]                      end_x,
    input  logic [gls_pkg::CRD_W-1:0]                      end_y,
    output gls_pkg::walk_sts_t                             sts,
    output logic [$clog2(GRID_WIDTH)+$clog2(GRID_HEIGHT)-1:0] addr
);

    import gls_pkg::*;

    localparam int CW  = cell_width(FRAC_BITS);
    localparam int XAW = $clog2(GRID_WIDTH);
    localparam int YAW = $clog2(GRID_HEIGHT);
    localparam int BXW = ((FRAC_BITS > CRD_W) ? FRAC_BITS : CRD_W) + 1;
    localparam int TW  = BXW + CRD_W;
    localparam int SQW = 2 * CRD_W;
    localparam int LW  = SQW + 1;
    localparam logic [63:0] SHORT_LIM = (64'd1 << (2 * FRAC_BITS)) / 64'd10000;

    // captured end points
    logic [CRD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;

    // setup stage A
    logic             negx_reg, negy_reg;
    logic [CRD_W-1:0] adx_reg, ady_reg;
    logic [CW-1:0]    c0x_reg, c0y_reg, ex_reg, ey_reg, rx0_reg, ry0_reg;
    logic [BXW-1:0]   bx_reg, by_reg;

    logic             negx_next, negy_next;
    logic [CRD_W-1:0] adx_next, ady_next;
    logic [CW-1:0]    c0x_next, c0y_next, ex_next, ey_next, rx0_next, ry0_next;
    logic [BXW-1:0]   bx_next, by_next;

    // setup stage B
    logic [SQW-1:0]   sqx_reg, sqy_reg;
    logic [TW-1:0]    tx0_reg, ty0_reg;

    // traversal cursor
    logic [CW-1:0]    cx_reg, cy_reg, rx_reg, ry_reg;
    logic [TW-1:0]    tx_reg, ty_reg;
    corner_t          phase_reg;
    logic             first_reg;

    logic [CW-1:0]    cx_next, cy_next, rx_next, ry_next;
    logic [TW-1:0]    tx_next, ty_next;
    corner_t          phase_next;
    logic             first_next;

    logic [LW-1:0]    len2;
    logic             short_seg;
    logic [TW-1:0]    incx, incy;
    logic [CW-1:0]    sx, sy, emit_x, emit_y;
    logic             go_x, go_y;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x0_reg <= start_x;
            y0_reg <= start_y;
            x1_reg <= end_x;
            y1_reg <= end_y;
        end
    end

    always_comb
    begin
        negx_next = (x1_reg < x0_reg);
        negy_next = (y1_reg < y0_reg);
        adx_next  = negx_next ? (x0_reg - x1_reg) : (x1_reg - x0_reg);
        ady_next  = negy_next ? (y0_reg - y1_reg) : (y1_reg - y0_reg);
        c0x_next  = CW'(x0_reg >> FRAC_BITS);
        c0y_next  = CW'(y0_reg >> FRAC_BITS);
        ex_next   = CW'(x1_reg >> FRAC_BITS);
        ey_next   = CW'(y1_reg >> FRAC_BITS);
        rx0_next  = (ex_next >= c0x_next) ? (ex_next - c0x_next) : (c0x_next - ex_next);
        ry0_next  = (ey_next >= c0y_next) ? (ey_next - c0y_next) : (c0y_next - ey_next);
        bx_next   = negx_next ? (BXW'(x0_reg) - (BXW'(c0x_next) << FRAC_BITS))
                              : (((BXW'(c0x_next) + BXW'(1)) << FRAC_BITS) - BXW'(x0_reg));
        by_next   = negy_next ? (BXW'(y0_reg) - (BXW'(c0y_next) << FRAC_BITS))
                              : (((BXW'(c0y_next) + BXW'(1)) << FRAC_BITS) - BXW'(y0_reg));
    end

    always_ff @(posedge clk)
    begin
        negx_reg <= negx_next;
        negy_reg <= negy_next;
        adx_reg  <= adx_next;
        ady_reg  <= ady_next;
        c0x_reg  <= c0x_next;
        c0y_reg  <= c0y_next;
        ex_reg   <= ex_next;
        ey_reg   <= ey_next;
        rx0_reg  <= rx0_next;
        ry0_reg  <= ry0_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        sqx_reg  <= SQW'(adx_reg) * SQW'(adx_reg);
        sqy_reg  <= SQW'(ady_reg) * SQW'(ady_reg);
        tx0_reg  <= TW'(bx_reg) * TW'(ady_reg);
        ty0_reg  <= TW'(by_reg) * TW'(adx_reg);
    end

    assign len2      = LW'(sqx_reg) + LW'(sqy_reg);
    assign short_seg = (64'(len2) <= SHORT_LIM);
    assign incx      = TW'(ady_reg) << FRAC_BITS;
    assign incy      = TW'(adx_reg) << FRAC_BITS;
    assign sx        = negx_reg ? (cx_reg - CW'(1)) : (cx_reg + CW'(1));
    assign sy        = negy_reg ? (cy_reg - CW'(1)) : (cy_reg + CW'(1));
    assign go_x      = (ry_reg == '0) || ((rx_reg != '0) && (tx_reg < ty_reg));
    assign go_y      = (rx_reg == '0) || ((ry_reg != '0) && (tx_reg > ty_reg));

    always_comb
    begin
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        tx_next    = tx_reg;
        ty_next    = ty_reg;
        phase_next = phase_reg;
        first_next = first_reg;
        emit_x     = cx_reg;
        emit_y     = cy_reg;
        if (first_reg)
        begin
            first_next = ctl.step ? 1'b0 : 1'b1;
        end
        else
        begin
            case (phase_reg)
                CRN_NONE:
                begin
                    if (go_x)
                    begin
                        emit_x  = sx;
                        cx_next = sx;
                        rx_next = rx_reg - CW'(1);
                        tx_next = tx_reg + incx;
                    end
                    else if (go_y)
                    begin
                        emit_y  = sy;
                        cy_next = sy;
                        ry_next = ry_reg - CW'(1);
                        ty_next = ty_reg + incy;
                    end
                    else
                    begin
                        emit_x     = sx;
                        phase_next = CRN_SIDE_X;
                    end
                end
                CRN_SIDE_X:
                begin
                    emit_y     = sy;
                    phase_next = CRN_SIDE_Y;
                end
                CRN_SIDE_Y:
                begin
                    emit_x     = sx;
                    emit_y     = sy;
                    cx_next    = sx;
                    cy_next    = sy;
                    rx_next    = rx_reg - CW'(1);
                    ry_next    = ry_reg - CW'(1);
                    tx_next    = tx_reg + incx;
                    ty_next    = ty_reg + incy;
                    phase_next = CRN_NONE;
                end
                default:
                begin
                    phase_next = CRN_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= CRN_NONE;
            first_reg <= 1'b0;
        end
        else if (ctl.init)
        begin
            phase_reg <= CRN_NONE;
            first_reg <= 1'b1;
        end
        else if (ctl.step)
        begin
            phase_reg <= phase_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            cx_reg <= short_seg ? ex_reg : c0x_reg;
            cy_reg <= short_seg ? ey_reg : c0y_reg;
            rx_reg <= short_seg ? '0 : rx0_reg;
            ry_reg <= short_seg ? '0 : ry0_reg;
            tx_reg <= tx0_reg;
            ty_reg <= ty0_reg;
        end
        else if (ctl.step)
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            tx_reg <= tx_next;
            ty_reg <= ty_next;
        end
    end

    assign sts.more    = first_reg || (phase_reg != CRN_NONE) || (rx_reg != '0)
                         || (ry_reg != '0);
    assign sts.in_grid = (32'(emit_x) < 32'(GRID_WIDTH)) && (32'(emit_y) < 32'(GRID_HEIGHT));
    assign addr        = {YAW'(emit_y), XAW'(emit_x)};

endmodule

### rtl/grid_line_of_sight_top.sv
// Grid line-of-sight top level: sequencer, solidity map RAM and result register.
// Depends on gls_pkg, gls_ram and gls_walker.
// Sequence: a write goes from idle straight to the result state; a query goes through
// prep, multiply, init and a walk over the cells up to the first solid one.
// Throughput: one item at a time; the next item is taken the cycle after the
// result is loaded. The walk issues one map read per cycle on the RAM read port.
// Reset: the map is cleared by a pass over all 2^(clog2(W)+clog2(H)) entries (4096 by
// default) during which no item is taken.
module grid_line_of_sight_top #(
    parameter int GRID_WIDTH  = gls_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = gls_pkg::DEF_GRID_HEIGHT,
    parameter int FRAC_BITS   = gls_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic                              operation,
    input  logic [gls_pkg::CELL_IN_W-1:0]     cell_x,
    input  logic [gls_pkg::CELL_IN_W-1:0]     cell_y,
    input  logic                              solid_value,
    input  logic [gls_pkg::CRD_W-1:0]         start_x,
    input  logic [gls_pkg::CRD_W-1:0]         start_y,
    input  logic [gls_pkg::CRD_W-1:0]         end_x,
    input  logic [gls_pkg::CRD_W-1:0]         end_y,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic                              hit,
    output logic [gls_pkg::COUNT_W-1:0]       cells_checked
);

    import gls_pkg::*;

    localparam int XAW = $clog2(GRID_WIDTH);
    localparam int YAW = $clog2(GRID_HEIGHT);
    localparam int AW  = XAW + YAW;

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic               pend_reg, pend_next;
    logic               pend_in_reg, pend_in_next;
    logic               hit_reg, hit_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               res_valid_reg, res_valid_next;
    logic               res_hit_reg, res_hit_next;
    logic [COUNT_W-1:0] res_cnt_reg, res_cnt_next;

    logic               item_xfer;
    logic               wr_ok;
    logic               slot_free;
    logic               solid_now;
    logic [COUNT_W-1:0] cnt_inc;

    logic               ram_we, ram_re, ram_wdata, ram_rdata;
    logic [AW-1:0]      ram_waddr, walk_addr;

    walk_ctl_t          wctl;
    walk_sts_t          wsts;

    assign item_xfer = item_valid && item_ready;
    assign wr_ok     = (32'(cell_x) < 32'(GRID_WIDTH)) && (32'(cell_y) < 32'(GRID_HEIGHT));
    assign slot_free = !res_valid_reg || result_ready;
    assign solid_now = pend_reg && pend_in_reg && ram_rdata;
    assign cnt_inc   = (cnt_reg == COUNT_MAX) ? cnt_reg : (cnt_reg + COUNT_W'(1));

    gls_ram #(
        .WIDTH (1),
        .DEPTH (1 << AW)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (walk_addr),
        .rdata (ram_rdata)
    );

    gls_walker #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .FRAC_BITS   (FRAC_BITS)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (wctl),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .sts     (wsts),
        .addr    (walk_addr)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    state_next = (operation == OP_QUERY) ? ST_PREP : ST_DONE;
                end
            end
            ST_PREP:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (solid_now || !wsts.more)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        item_ready = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = clr_cnt_reg;
        ram_wdata  = 1'b0;
        ram_re     = 1'b0;
        wctl       = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
                wctl.load  = item_xfer;
                ram_we     = item_xfer && (operation == OP_WRITE) && wr_ok;
                ram_waddr  = {YAW'(cell_y), XAW'(cell_x)};
                ram_wdata  = solid_value;
            end
            ST_INIT:
            begin
                wctl.init = 1'b1;
            end
            ST_WALK:
            begin
                ram_re    = wsts.more && !solid_now;
                wctl.step = wsts.more && !solid_now;
            end
            ST_PREP, ST_MUL, ST_DONE:
            begin
                wctl = '0;
            end
            default:
            begin
                wctl = '0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        pend_next      = pend_reg;
        pend_in_next   = pend_in_reg;
        hit_next       = hit_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg;
        res_hit_next   = res_hit_reg;
        res_cnt_next   = res_cnt_reg;

        if (state_reg == ST_CLEAR)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end
        if ((state_reg == ST_IDLE) || (state_reg == ST_INIT))
        begin
            pend_next = 1'b0;
            hit_next  = 1'b0;
            cnt_next  = '0;
        end
        if (state_reg == ST_WALK)
        begin
            hit_next     = solid_now;
            cnt_next     = pend_reg ? cnt_inc : cnt_reg;
            pend_next    = wsts.more && !solid_now;
            pend_in_next = wsts.in_grid;
        end

        if (res_valid_reg && result_ready)
        begin
            res_valid_next = 1'b0;
        end
        if ((state_reg == ST_DONE) && slot_free)
        begin
            res_valid_next = 1'b1;
            res_hit_next   = hit_reg;
            res_cnt_next   = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_in_reg <= pend_in_next;
        hit_reg     <= hit_next;
        cnt_reg     <= cnt_next;
        res_hit_reg <= res_hit_next;
        res_cnt_reg <= res_cnt_next;
    end

    assign result_valid  = res_valid_reg;
    assign hit           = res_hit_reg;
    assign cells_checked = res_cnt_reg;

`ifndef ASSERT_OFF
    a_hit_counts: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!hit || (cells_checked != '0)))
        else $error("hit reported with zero cells checked");

    a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && $past(state_reg == ST_CLEAR) |-> $past(&clr_cnt_reg))
        else $error("map clear ended before sweeping every entry");

    a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_IDLE)))
        else $error("map write outside clear or idle");

    a_stop_on_solid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) && solid_now |=> (state_reg == ST_DONE) && hit_reg)
        else $error("walk did not stop at solid cell");
`endif

endmodule

### tb/tb_grid_line_of_sight_top.sv
// Testbench for grid_line_of_sight_top: directed and random cell writes and line queries,
// each result checked against a behavioral cell walk that tracks its own copy of the map.
// Depends on gls_pkg and the RTL under rtl/.
module tb_grid_line_of_sight_top;
    import gls_pkg::*;

    localparam int GRID_W       = DEF_GRID_WIDTH;
    localparam int GRID_H       = DEF_GRID_HEIGHT;
    localparam int FRAC         = DEF_FRAC_BITS;
    localparam int COORD_MAX    = (1 << CRD_W) - 1;
    localparam int RANDOM_ITEMS = 1700;
    localparam int TAIL_CYCLES  = 256;
    localparam int CYCLE_LIMIT  = 2_000_000;

    typedef struct {
        logic                 op;
        logic [CELL_IN_W-1:0] cx;
        logic [CELL_IN_W-1:0] cy;
        logic                 solid;
        logic [CRD_W-1:0]     sx;
        logic [CRD_W-1:0]     sy;
        logic [CRD_W-1:0]     ex;
        logic [CRD_W-1:0]     ey;
    } sight_item_t;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] cells;
    } sight_result_t;

    class sight_scoreboard;
        bit            solid_cells [GRID_W*GRID_H];
        sight_result_t expected_q [$];
        int            failures;
        longint        walk_count;
        bit            walk_hit;

        function bit probe(longint cx, longint cy);
            walk_count++;
            if (cx < 0 || cy < 0 || cx >= GRID_W || cy >= GRID_H)
                return 0;
            if (solid_cells[cy * GRID_W + cx])
            begin
                walk_hit = 1;
                return 1;
            end
            return 0;
        endfunction

        function void trace_segment(longint x0, longint y0, longint x1, longint y1);
            longint dx, dy, adx, ady, cx, cy, ex, ey, stx, sty, rx, ry, bx, by, tx, ty;
            int order;
            dx  = x1 - x0;
            dy  = y1 - y0;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            cx  = x0 >> FRAC;
            cy  = y0 >> FRAC;
            ex  = x1 >> FRAC;
            ey  = y1 >> FRAC;
            stx = (dx < 0) ? -1 : 1;
            sty = (dy < 0) ? -1 : 1;
            rx  = (ex > cx) ? ex - cx : cx - ex;
            ry  = (ey > cy) ? ey - cy : cy - ey;
            walk_count = 0;
            walk_hit   = 0;
            // under 0.01 tile: end cell only
            if ((adx * adx + ady * ady) * 10000 <= (longint'(1) << (2 * FRAC)))
            begin
                void'(probe(ex, ey));
                return;
            end
            if (probe(cx, cy))
                return;
            while (rx > 0 || ry > 0)
            begin
                if (rx == 0)
                    order = 1;
                else if (ry == 0)
                    order = -1;
                else
                begin
                    bx = (dx > 0) ? (((cx + 1) << FRAC) - x0) : (x0 - (cx << FRAC));
                    by = (dy > 0) ? (((cy + 1) << FRAC) - y0) : (y0 - (cy << FRAC));
                    tx = bx * ady;
                    ty = by * adx;
                    order = (tx < ty) ? -1 : ((tx > ty) ? 1 : 0);
                end
                if (order < 0)
                begin
                    cx += stx;
                    rx--;
                end
                else if (order > 0)
                begin
                    cy += sty;
                    ry--;
                end
                else
                begin
                    // exact corner: both side cells, then the diagonal one
                    if (probe(cx + stx, cy))
                        return;
                    if (probe(cx, cy + sty))
                        return;
                    cx += stx;
                    cy += sty;
                    rx--;
                    ry--;
                end
                if (probe(cx, cy))
                    return;
            end
        endfunction

        function void note_transfer(sight_item_t it);
            sight_result_t r;
            r = '0;
            if (it.op == OP_WRITE)
            begin
                if (int'(it.cx) < GRID_W && int'(it.cy) < GRID_H)
                    solid_cells[int'(it.cy) * GRID_W + int'(it.cx)] = it.solid;
            end
            else
            begin
                trace_segment(it.sx, it.sy, it.ex, it.ey);
                r.hit   = walk_hit;
                r.cells = (walk_count > COUNT_MAX) ? COUNT_MAX : walk_count[COUNT_W-1:0];
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic hit_seen, logic [COUNT_W-1:0] cells_seen);
            sight_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transfer: hit %0d, cells_checked %0d",
                       hit_seen, cells_seen);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            if (hit_seen !== want.hit)
            begin
                $error("hit: expected %0d, actual %0d", want.hit, hit_seen);
                failures++;
            end
            if (cells_seen !== want.cells)
            begin
                $error("cells_checked: expected %0d, actual %0d", want.cells, cells_seen);
                failures++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_ready;
    logic                 operation;
    logic [CELL_IN_W-1:0] cell_x;
    logic [CELL_IN_W-1:0] cell_y;
    logic                 solid_value;
    logic [CRD_W-1:0]     start_x;
    logic [CRD_W-1:0]     start_y;
    logic [CRD_W-1:0]     end_x;
    logic [CRD_W-1:0]     end_y;
    logic                 result_valid;
    logic                 result_ready;
    logic                 hit;
    logic [COUNT_W-1:0]   cells_checked;

    sight_scoreboard sb = new();
    int send_idle_pct = 31;
    int recv_idle_pct = 31;
    int cycle_count   = 0;

    grid_line_of_sight_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .operation     (operation),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .solid_value   (solid_value),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .hit           (hit),
        .cells_checked (cells_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
        result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        sight_item_t seen;
        if (rst_n && item_valid && item_ready)
        begin
            seen.op    = operation;
            seen.cx    = cell_x;
            seen.cy    = cell_y;
            seen.solid = solid_value;
            seen.sx    = start_x;
            seen.sy    = start_y;
            seen.ex    = end_x;
            seen.ey    = end_y;
            sb.note_transfer(seen);
        end
        if (rst_n && result_valid && result_ready)
            sb.check_result(hit, cells_checked);
    end

    function automatic logic [CRD_W-1:0] clip(int v);
        return (v < 0) ? '0 : ((v > COORD_MAX) ? COORD_MAX[CRD_W-1:0] : v[CRD_W-1:0]);
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return COORD_MAX;
            2:       return (1 << FRAC) - 1;
            3:       return 1 << FRAC;
            default: return $urandom_range(0, COORD_MAX);
        endcase
    endfunction

    function automatic sight_item_t noise_item();
        sight_item_t it;
        it.op    = 1'($urandom_range(0, 1));
        it.cx    = CELL_IN_W'($urandom);
        it.cy    = CELL_IN_W'($urandom);
        it.solid = 1'($urandom_range(0, 1));
        it.sx    = CRD_W'($urandom);
        it.sy    = CRD_W'($urandom);
        it.ex    = CRD_W'($urandom);
        it.ey    = CRD_W'($urandom);
        return it;
    endfunction

    task automatic send_item(input sight_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        operation   <= it.op;
        cell_x      <= it.cx;
        cell_y      <= it.cy;
        solid_value <= it.solid;
        start_x     <= it.sx;
        start_y     <= it.sy;
        end_x       <= it.ex;
        end_y       <= it.ey;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic write_cell(input int x, input int y, input logic v);
        sight_item_t it;
        it       = noise_item();
        it.op    = OP_WRITE;
        it.cx    = CELL_IN_W'(x);
        it.cy    = CELL_IN_W'(y);
        it.solid = v;
        send_item(it);
    endtask

    task automatic query_line(input int sx, input int sy, input int ex, input int ey);
        sight_item_t it;
        it    = noise_item();
        it.op = OP_QUERY;
        it.sx = clip(sx);
        it.sy = clip(sy);
        it.ex = clip(ex);
        it.ey = clip(ey);
        send_item(it);
    endtask

    task automatic random_query();
        int sel, sx, sy, ex, ey, d, f;
        sel = $urandom_range(0, 99);
        sx  = $urandom_range(0, COORD_MAX);
        sy  = $urandom_range(0, COORD_MAX);
        ex  = $urandom_range(0, COORD_MAX);
        ey  = $urandom_range(0, COORD_MAX);
        if (sel < 30)
            ;
        else if (sel < 55)
        begin
            ex = sx + $urandom_range(0, 1536) - 768;
            ey = sy + $urandom_range(0, 1536) - 768;
        end
        else if (sel < 65)
        begin
            ex = sx + $urandom_range(0, 6) - 3;
            ey = sy + $urandom_range(0, 6) - 3;
        end
        else if (sel < 80)
        begin
            // equal slopes from matching offsets give corner crossings
            case ($urandom_range(0, 2))
                0:       f = 0;
                1:       f = 128;
                default: f = $urandom_range(0, 255);
            endcase
            sx = $urandom_range(0, GRID_W - 1) * 256 + f;
            sy = $urandom_range(0, GRID_H - 1) * 256 + f;
            d  = $urandom_range(1, 2048);
            ex = $urandom_range(0, 1) ? sx + d : sx - d;
            ey = $urandom_range(0, 1) ? sy + d : sy - d;
        end
        else if (sel < 90)
        begin
            if ($urandom_range(0, 1))
                ey = sy;
            else
                ex = sx;
        end
        else
        begin
            sx = extreme_coord();
            sy = extreme_coord();
            ex = extreme_coord();
            ey = extreme_coord();
        end
        query_line(sx, sy, ex, ey);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        operation    = OP_WRITE;
        cell_x       = '0;
        cell_y       = '0;
        solid_value  = 1'b0;
        start_x      = '0;
        start_y      = '0;
        end_x        = '0;
        end_y        = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty map, full diagonals through every corner: count saturates
        query_line(128, 128, 16256, 16256);
        query_line(COORD_MAX, COORD_MAX, 0, 0);
        write_cell(0, 0, 1'b1);
        write_cell(GRID_W - 1, GRID_H - 1, 1'b1);
        write_cell(GRID_W - 1, 0, 1'b1);
        write_cell(0, GRID_H - 1, 1'b1);
        query_line(128, 128, 16256, 16256);
        query_line(COORD_MAX, COORD_MAX, 0, 0);
        query_line(0, COORD_MAX, COORD_MAX, 0);
        // short segments: the first three are end cell only, the last is just over the limit
        query_line(511, 511, 513, 512);
        query_line(1, 1, 0, 0);
        query_line(255, 255, 257, 256);
        query_line(511, 511, 513, 513);
        // start on a cell edge moving left
        query_line(256, 128, 10, 128);
        query_line(128, 32 * 256 + 5, COORD_MAX, 32 * 256 + 5);
        query_line(63 * 256 + 100, 62 * 256, 63 * 256 + 100, 0);
        write_cell(0, 0, 1'b0);
        write_cell(10, 20, 1'b1);
        query_line(10 * 256 + 128, 0, 10 * 256 + 128, COORD_MAX);
        write_cell(GRID_W - 1, GRID_H - 1, 1'b0);
        query_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        query_line(0, 0, 0, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 600)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n == 900)
            begin
                send_idle_pct = 31;
                recv_idle_pct = 31;
            end
            if ($urandom_range(0, 99) < 35)
                write_cell($urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1),
                           1'($urandom_range(0, 1)));
            else
                random_query();
        end
        item_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
